### src/bxg_pkg.sv
// Package for the binary extended gcd / modular inverse block.
// Holds the default operand width, the sequencer states and the step-unit operation codes.
// No dependencies.
`default_nettype none

package bxg_pkg;

  // Default operand width in bits
  localparam int unsigned OPERAND_WIDTH_DEF = 31;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_STRIP  = 7'b0000010,
    ST_LOOP   = 7'b0000100,
    ST_CHECK  = 7'b0001000,
    ST_REDUCE = 7'b0010000,
    ST_FIX    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } bxg_state_e;

  // Operations of the shared step unit
  typedef enum logic {
    OP_HALVE = 1'b0,
    OP_SUB   = 1'b1
  } step_op_e;

endpackage

`default_nettype wire

### src/bxg_in_if.sv
// Input channel interface: valid/ready handshake carrying the two operands.
// Depends on bxg_pkg for the default operand width.
`default_nettype none

interface bxg_in_if #(
  parameter int unsigned OPERAND_WIDTH = bxg_pkg::OPERAND_WIDTH_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] operand_a;
  logic [OPERAND_WIDTH-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

`default_nettype wire

### src/bxg_out_if.sv
// Result channel interface: valid/ready handshake carrying gcd, coefficients and inverse.
// Depends on bxg_pkg for the default operand width.
`default_nettype none

interface bxg_out_if #(
  parameter int unsigned OPERAND_WIDTH = bxg_pkg::OPERAND_WIDTH_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] gcd_value;
  logic [OPERAND_WIDTH:0]   coef_a;
  logic [OPERAND_WIDTH:0]   coef_b;
  logic                     inverse_valid;
  logic [OPERAND_WIDTH-1:0] inverse_value;

  modport source (output valid, output gcd_value, output coef_a, output coef_b,
                  output inverse_valid, output inverse_value, input ready);
  modport sink   (input valid, input gcd_value, input coef_a, input coef_b,
                  input inverse_valid, input inverse_value, output ready);
endinterface

`default_nettype wire

### src/binary_extended_gcd_inverse.sv
// Top level of the binary extended gcd / modular inverse block.
// Depends on bxg_pkg, bxg_in_if, bxg_out_if and bxg_core.
`default_nettype none

// One operand pair in, one result out: gcd, Bezout coefficients (a*x + b*y = gcd) and
// the inverse of a modulo b with its valid flag. The core works on one pair at a time and
// takes ready low while busy. A transaction first strips the common factors of two, then
// runs the halving and subtraction steps of the binary Euclid loop and a check, and when
// the inverse exists a bit-serial reduction and a fold, all through the one shared step
// unit. A result register on the output lets the next transaction be taken while the
// previous result waits.

module binary_extended_gcd_inverse #(
  parameter int unsigned OPERAND_WIDTH = bxg_pkg::OPERAND_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bxg_in_if.sink     in_i,
  bxg_out_if.source  out_o
);

  localparam int unsigned W = OPERAND_WIDTH;

  logic         core_idle;
  logic         core_res_valid;
  logic         res_take;
  logic [W-1:0] core_gcd;
  logic [W:0]   core_coef_a;
  logic [W:0]   core_coef_b;
  logic         core_inv_valid;
  logic [W-1:0] core_inv_value;

  logic         out_valid_q;
  logic [W-1:0] gcd_q;
  logic [W:0]   coef_a_q;
  logic [W:0]   coef_b_q;
  logic         inv_valid_q;
  logic [W-1:0] inv_value_q;

  assign in_i.ready = core_idle;

  bxg_core #(
    .OPERAND_WIDTH (W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_i.valid & core_idle),
    .a_i         (in_i.operand_a),
    .b_i         (in_i.operand_b),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_take_i  (res_take),
    .gcd_o       (core_gcd),
    .coef_a_o    (core_coef_a),
    .coef_b_o    (core_coef_b),
    .inv_valid_o (core_inv_valid),
    .inv_value_o (core_inv_value)
  );

  // Output register takes the result when empty or being drained
  assign res_take = core_res_valid & (~out_valid_q | out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      gcd_q       <= core_gcd;
      coef_a_q    <= core_coef_a;
      coef_b_q    <= core_coef_b;
      inv_valid_q <= core_inv_valid;
      inv_value_q <= core_inv_value;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.gcd_value     = gcd_q;
  assign out_o.coef_a        = coef_a_q;
  assign out_o.coef_b        = coef_b_q;
  assign out_o.inverse_valid = inv_valid_q;
  assign out_o.inverse_value = inv_value_q;

endmodule

`default_nettype wire

### src/bxg_step_unit.sv
// Shared step unit: halves or subtracts a coefficient pair and a magnitude.
// Combinational; depends on bxg_pkg for the operation codes.
`default_nettype none

module bxg_step_unit #(
  parameter int unsigned OPERAND_WIDTH = bxg_pkg::OPERAND_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH    = OPERAND_WIDTH + 3
) (
  input  bxg_pkg::step_op_e        op_i,
  input  logic [COEF_WIDTH-1:0]    p0_i,
  input  logic [COEF_WIDTH-1:0]    p1_i,
  input  logic [COEF_WIDTH-1:0]    q0_i,
  input  logic [COEF_WIDTH-1:0]    q1_i,
  input  logic [OPERAND_WIDTH-1:0] xr_i,
  input  logic [OPERAND_WIDTH-1:0] yr_i,
  input  logic [OPERAND_WIDTH:0]   m_i,
  input  logic [OPERAND_WIDTH:0]   n_i,
  output logic [COEF_WIDTH-1:0]    p0_o,
  output logic [COEF_WIDTH-1:0]    p1_o,
  output logic [OPERAND_WIDTH+1:0] mag_o
);

  localparam int unsigned EXT = COEF_WIDTH - OPERAND_WIDTH;

  logic [COEF_WIDTH-1:0] xr_ext;
  logic [COEF_WIDTH-1:0] yr_ext;
  logic [COEF_WIDTH-1:0] p0_asr;
  logic [COEF_WIDTH-1:0] p1_asr;
  logic                  pair_even;

  assign xr_ext    = {{EXT{1'b0}}, xr_i};
  assign yr_ext    = {{EXT{1'b0}}, yr_i};
  assign p0_asr    = {p0_i[COEF_WIDTH-1], p0_i[COEF_WIDTH-1:1]};
  assign p1_asr    = {p1_i[COEF_WIDTH-1], p1_i[COEF_WIDTH-1:1]};
  assign pair_even = ~(p0_i[0] | p1_i[0]);

  always_comb begin
    case (op_i)
      bxg_pkg::OP_HALVE: begin
        // floor halving; odd pair first gets (+yr, -xr) added
        if (pair_even) begin
          p0_o = p0_asr;
          p1_o = p1_asr;
        end else begin
          p0_o = p0_asr + (yr_ext >> 1) + COEF_WIDTH'(p0_i[0] & yr_i[0]);
          p1_o = p1_asr - (xr_ext >> 1) - COEF_WIDTH'(~p1_i[0] & xr_i[0]);
        end
        mag_o = {2'b00, m_i[OPERAND_WIDTH:1]};
      end
      bxg_pkg::OP_SUB: begin
        p0_o  = p0_i - q0_i;
        p1_o  = p1_i - q1_i;
        // top bit is the borrow
        mag_o = {1'b0, m_i} - {1'b0, n_i};
      end
      default: begin
        p0_o  = p0_i;
        p1_o  = p1_i;
        mag_o = {1'b0, m_i};
      end
    endcase
  end

endmodule

`default_nettype wire

### src/bxg_core.sv
// Sequencer and state registers of the binary extended gcd, plus the inverse reduction.
// Depends on bxg_pkg and instantiates bxg_step_unit.
`default_nettype none

module bxg_core #(
  parameter int unsigned OPERAND_WIDTH = bxg_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [OPERAND_WIDTH-1:0] a_i,
  input  logic [OPERAND_WIDTH-1:0] b_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  logic                     res_take_i,
  output logic [OPERAND_WIDTH-1:0] gcd_o,
  output logic [OPERAND_WIDTH:0]   coef_a_o,
  output logic [OPERAND_WIDTH:0]   coef_b_o,
  output logic                     inv_valid_o,
  output logic [OPERAND_WIDTH-1:0] inv_value_o
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned CW    = W + 3;
  localparam int unsigned KW    = $clog2(W);
  localparam int unsigned CNTW  = $clog2(CW);

  bxg_pkg::bxg_state_e state_q, state_d;

  logic [W-1:0]    xr_q, xr_d, yr_q, yr_d, b_q, b_d;
  logic [W-1:0]    u_q, u_d, v_q, v_d, g_q, g_d;
  logic [KW-1:0]   k_q, k_d;
  logic [CW-1:0]   ca_q, ca_d, cb_q, cb_d, cc_q, cc_d, cd_q, cd_d;
  logic            neg_q, neg_d, ok_q, ok_d;
  logic [CW-1:0]   mag_q, mag_d;
  logic [W-1:0]    r_q, r_d, inv_q, inv_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  // step unit hookup
  bxg_pkg::step_op_e su_op;
  logic [CW-1:0]     su_p0, su_p1, su_q0, su_q1, su_r0, su_r1;
  logic [W:0]        su_m, su_n;
  logic [W+1:0]      su_mag;
  logic              u_ge_v;
  logic [W:0]        red_m;

  bxg_step_unit #(
    .OPERAND_WIDTH (W),
    .COEF_WIDTH    (CW)
  ) u_step (
    .op_i  (su_op),
    .p0_i  (su_p0),
    .p1_i  (su_p1),
    .q0_i  (su_q0),
    .q1_i  (su_q1),
    .xr_i  (xr_q),
    .yr_i  (yr_q),
    .m_i   (su_m),
    .n_i   (su_n),
    .p0_o  (su_r0),
    .p1_o  (su_r1),
    .mag_o (su_mag)
  );

  assign u_ge_v = (u_q >= v_q);
  assign red_m  = {r_q, mag_q[CW-1]};

  // Step unit operand selection
  always_comb begin
    su_op = bxg_pkg::OP_HALVE;
    su_p0 = ca_q;
    su_p1 = cb_q;
    su_q0 = cc_q;
    su_q1 = cd_q;
    su_m  = {1'b0, u_q};
    su_n  = {1'b0, v_q};
    case (state_q)
      bxg_pkg::ST_LOOP: begin
        if (!u_q[0]) begin
          su_op = bxg_pkg::OP_HALVE;
        end else if (!v_q[0]) begin
          su_op = bxg_pkg::OP_HALVE;
          su_p0 = cc_q;
          su_p1 = cd_q;
          su_m  = {1'b0, v_q};
        end else if (u_ge_v) begin
          su_op = bxg_pkg::OP_SUB;
        end else begin
          su_op = bxg_pkg::OP_SUB;
          su_p0 = cc_q;
          su_p1 = cd_q;
          su_q0 = ca_q;
          su_q1 = cb_q;
          su_m  = {1'b0, v_q};
          su_n  = {1'b0, u_q};
        end
      end
      bxg_pkg::ST_REDUCE: begin
        su_op = bxg_pkg::OP_SUB;
        su_m  = red_m;
        su_n  = {1'b0, b_q};
      end
      bxg_pkg::ST_FIX: begin
        su_op = bxg_pkg::OP_SUB;
        su_m  = {1'b0, b_q};
        su_n  = {1'b0, r_q};
      end
      default: begin
        su_op = bxg_pkg::OP_HALVE;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    xr_d = xr_q;  yr_d = yr_q;  b_d = b_q;
    u_d  = u_q;   v_d  = v_q;   g_d = g_q;  k_d = k_q;
    ca_d = ca_q;  cb_d = cb_q;  cc_d = cc_q;  cd_d = cd_q;
    neg_d = neg_q;  ok_d = ok_q;  mag_d = mag_q;
    r_d = r_q;  inv_d = inv_q;  cnt_d = cnt_q;
    case (state_q)
      bxg_pkg::ST_IDLE: begin
        if (start_i) begin
          xr_d = a_i;
          yr_d = b_i;
          b_d  = b_i;
          k_d  = '0;
          if (a_i == '0) begin
            g_d     = b_i;
            cc_d    = '0;
            cd_d    = CW'(b_i != '0);
            state_d = bxg_pkg::ST_CHECK;
          end else if (b_i == '0) begin
            g_d     = a_i;
            cc_d    = CW'(1);
            cd_d    = '0;
            state_d = bxg_pkg::ST_CHECK;
          end else begin
            state_d = bxg_pkg::ST_STRIP;
          end
        end
      end
      bxg_pkg::ST_STRIP: begin
        // divide out the common power of two
        if (!xr_q[0] && !yr_q[0]) begin
          xr_d = xr_q >> 1;
          yr_d = yr_q >> 1;
          k_d  = k_q + KW'(1);
        end else begin
          u_d  = xr_q;
          v_d  = yr_q;
          ca_d = CW'(1);
          cb_d = '0;
          cc_d = '0;
          cd_d = CW'(1);
          state_d = bxg_pkg::ST_LOOP;
        end
      end
      bxg_pkg::ST_LOOP: begin
        if (!u_q[0]) begin
          u_d  = su_mag[W-1:0];
          ca_d = su_r0;
          cb_d = su_r1;
        end else if (!v_q[0]) begin
          v_d  = su_mag[W-1:0];
          cc_d = su_r0;
          cd_d = su_r1;
        end else if (u_ge_v) begin
          u_d  = su_mag[W-1:0];
          ca_d = su_r0;
          cb_d = su_r1;
          if (su_mag[W-1:0] == '0) begin
            g_d     = W'(v_q << k_q);
            state_d = bxg_pkg::ST_CHECK;
          end
        end else begin
          v_d  = su_mag[W-1:0];
          cc_d = su_r0;
          cd_d = su_r1;
        end
      end
      bxg_pkg::ST_CHECK: begin
        // inverse only when gcd is one and modulus is non-zero
        if ((g_q == W'(1)) && (b_q != '0)) begin
          neg_d   = cc_q[CW-1];
          mag_d   = cc_q[CW-1] ? (CW'(0) - cc_q) : cc_q;
          r_d     = '0;
          cnt_d   = '0;
          state_d = bxg_pkg::ST_REDUCE;
        end else begin
          ok_d    = 1'b0;
          inv_d   = '0;
          state_d = bxg_pkg::ST_DONE;
        end
      end
      bxg_pkg::ST_REDUCE: begin
        // restoring remainder, one bit of |x| per cycle
        r_d   = su_mag[W+1] ? red_m[W-1:0] : su_mag[W-1:0];
        mag_d = mag_q << 1;
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(CW - 1)) begin
          state_d = bxg_pkg::ST_FIX;
        end
      end
      bxg_pkg::ST_FIX: begin
        // negative coefficient folds back into 0..b-1
        inv_d   = (neg_q && (r_q != '0)) ? su_mag[W-1:0] : r_q;
        ok_d    = 1'b1;
        state_d = bxg_pkg::ST_DONE;
      end
      bxg_pkg::ST_DONE: begin
        if (res_take_i) begin
          state_d = bxg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bxg_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bxg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    xr_q <= xr_d;  yr_q <= yr_d;  b_q <= b_d;
    u_q  <= u_d;   v_q  <= v_d;   g_q <= g_d;  k_q <= k_d;
    ca_q <= ca_d;  cb_q <= cb_d;  cc_q <= cc_d;  cd_q <= cd_d;
    neg_q <= neg_d;  ok_q <= ok_d;  mag_q <= mag_d;
    r_q <= r_d;  inv_q <= inv_d;  cnt_q <= cnt_d;
  end

  assign idle_o      = (state_q == bxg_pkg::ST_IDLE);
  assign res_valid_o = (state_q == bxg_pkg::ST_DONE);
  assign gcd_o       = g_q;
  assign coef_a_o    = cc_q[W:0];
  assign coef_b_o    = cd_q[W:0];
  assign inv_valid_o = ok_q;
  assign inv_value_o = inv_q;

endmodule

`default_nettype wire

### src/bxg_checker.sv
// Port-level checker for binary_extended_gcd_inverse, with the bind that attaches it.
// Depends on bxg_pkg for the default operand width.
`default_nettype none

module bxg_checker #(
  parameter int unsigned OPERAND_WIDTH = bxg_pkg::OPERAND_WIDTH_DEF
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [OPERAND_WIDTH-1:0] gcd_i,
  input logic [OPERAND_WIDTH:0]   coef_a_i,
  input logic [OPERAND_WIDTH:0]   coef_b_i,
  input logic                     inv_valid_i,
  input logic [OPERAND_WIDTH-1:0] inv_value_i
);

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(gcd_i) && $stable(coef_a_i)
      && $stable(coef_b_i) && $stable(inv_valid_i) && $stable(inv_value_i))
    else $error("result changed while stalled");

  // The core is busy straight after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready still high after accepting a transaction");

  // No inverse means a zero inverse value
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !inv_valid_i |-> inv_value_i == '0)
    else $error("inverse value non-zero without valid flag");

  // An inverse exists only for a gcd of one
  a_inv_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && inv_valid_i |-> gcd_i == OPERAND_WIDTH'(1))
    else $error("inverse flagged with gcd other than one");

  // Both operands zero gives zero coefficients
  a_zero_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gcd_i == '0 |-> coef_a_i == '0 && coef_b_i == '0)
    else $error("non-zero coefficients for zero gcd");

endmodule

bind binary_extended_gcd_inverse bxg_checker #(
  .OPERAND_WIDTH (OPERAND_WIDTH)
) u_bxg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .gcd_i       (out_o.gcd_value),
  .coef_a_i    (out_o.coef_a),
  .coef_b_i    (out_o.coef_b),
  .inv_valid_i (out_o.inverse_valid),
  .inv_value_i (out_o.inverse_value)
);

`default_nettype wire
